@@ rtl/adsr_pkg.sv @@
// shared types, codes and datapath widths for the exponential adsr envelope generator
`timescale 1ns / 1ps

package adsr_pkg;

    // defaults of the top-level parameters
    localparam int TIME_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF = 16;
    localparam int EXP_DEPTH_DEF = 1024;

    // series used to build e, e^3 and the exponential table
    localparam int SERIES_TERMS = 80;
    localparam int Q32          = 32;
    localparam int SER_W        = 38;

    // shared multiplier and divider widths, sized for the full parameter ranges
    localparam int MUL_A_W   = 40;
    localparam int MUL_B_W   = 28;
    localparam int MUL_P_W   = 64;
    localparam int DIV_N_W   = 64;
    localparam int DIV_D_W   = 40;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    // gate event codes
    localparam logic [1:0] GATE_ON  = 2'd1;
    localparam logic [1:0] GATE_OFF = 2'd2;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_ATTACK  = 2'd0,
        REG_DECAY   = 2'd1,
        REG_SUSTAIN = 2'd2,
        REG_RELEASE = 2'd3
    } cfg_reg_t;

    // envelope stages
    typedef enum logic [2:0] {
        ST_HALT    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } stage_t;

    // which series the start-up sequence is summing
    typedef enum logic [1:0] {
        INIT_E,
        INIT_E3,
        INIT_TAB
    } init_phase_t;

    // sequencer states
    typedef enum logic [4:0] {
        SQ_SER_START,
        SQ_SER_MUL,
        SQ_SER_DIV,
        SQ_SER_WAIT,
        SQ_SER_END,
        SQ_TAB_WAIT,
        SQ_IDLE,
        SQ_EVENT,
        SQ_BIAS_WAIT,
        SQ_CURVE,
        SQ_IDX_DIV,
        SQ_IDX_WAIT,
        SQ_LVL1,
        SQ_LVL2,
        SQ_LVL3,
        SQ_STAGE_END,
        SQ_DEC_DIV,
        SQ_DEC_WAIT,
        SQ_FINISH
    } seq_state_t;

endpackage

@@ rtl/adsr_mul.sv @@
// shared signed multiplier with a registered product
`timescale 1ns / 1ps

module adsr_mul (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [adsr_pkg::MUL_A_W-1:0]  a,
    input  logic signed [adsr_pkg::MUL_B_W-1:0]  b,
    output logic signed [adsr_pkg::MUL_P_W-1:0]  prod
);
    import adsr_pkg::*;

    logic signed [MUL_A_W+MUL_B_W-1:0] full;
    logic signed [MUL_P_W-1:0]         prod_reg;
    logic signed [MUL_P_W-1:0]         prod_next;

    // full product, all used values fit the lower word
    assign full      = a * b;
    assign prod_next = signed'(full[MUL_P_W-1:0]);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

@@ rtl/adsr_div.sv @@
// shared radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module adsr_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [adsr_pkg::DIV_N_W-1:0]   dividend,
    input  logic [adsr_pkg::DIV_D_W-1:0]   divisor,
    output logic [adsr_pkg::DIV_N_W-1:0]   quotient,
    output logic                           done
);
    import adsr_pkg::*;

    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0]   dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W:0]     diff;

    // partial remainder with the next dividend bit brought in
    assign shifted = {rem_reg, quo_reg[DIV_N_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIV_N_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dsr_reg}) begin
                rem_next = diff[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ rtl/adsr_exp_ram.sv @@
// exponential table memory, one write port and one registered read port
`timescale 1ns / 1ps

module adsr_exp_ram #(
    parameter int DEPTH = 1025,
    parameter int WIDTH = 17
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/adsr_envelope_generator_unit.sv @@
// Exponential ADSR envelope generator: one gate word in, one level word out per audio sample.
// After reset the block builds e, e^3 and its exp(-3k/N) table with an integer series on the
// shared multiplier and divider; s_ready stays low for this, while configuration writes are
// taken throughout. Samples in attack, decay or release, the start of a stage and the step
// from attack into decay wait on the 64-step radix-2 divider, which serves the table index
// and the curve bias one after the other; halt and sustain samples skip it. A new word is
// taken while the previous result still waits in the output register. Configuration may be
// written only while the block is idle.
`timescale 1ns / 1ps

module adsr_envelope_generator_unit #(
    parameter int TIME_BITS       = adsr_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS       = adsr_pkg::FRAC_BITS_DEF,
    parameter int EXP_TABLE_DEPTH = adsr_pkg::EXP_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [((TIME_BITS > FRAC_BITS + 1) ? TIME_BITS : FRAC_BITS + 1)-1:0] cfg_data,
    // gate event channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_gate_event,
    // level channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [FRAC_BITS:0]   m_level,
    output logic                 m_done_res
);
    import adsr_pkg::*;

    localparam int LVL_W  = FRAC_BITS + 1;
    localparam int B_W    = FRAC_BITS + 2;
    localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int NUM_W  = $clog2(3 * EXP_TABLE_DEPTH + 1);
    localparam int SN_W   = $clog2(SERIES_TERMS + 2);
    localparam int SD_W   = $clog2(EXP_TABLE_DEPTH * (SERIES_TERMS + 1) + 1);

    localparam logic [LVL_W-1:0]   LVL_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [63:0]        ONE_Q32   = 64'd1 << Q32;
    localparam logic [63:0]        ONE_WIDE  = 64'd1 << (Q32 + FRAC_BITS);
    localparam logic [63:0]        HALF_LSB  = 64'd1 << (FRAC_BITS - 1);
    localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(EXP_TABLE_DEPTH);
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // duration of zero counts as one
    function automatic logic [TIME_BITS-1:0] len_or_one(input logic [TIME_BITS-1:0] v);
        return (v == '0) ? TIME_BITS'(1) : v;
    endfunction

    // round the Q2.2F sum to Q1.F and keep it within 0..1.0
    function automatic logic [LVL_W-1:0] clamp_level(input logic signed [63:0] total);
        logic [63:0] v;
        v = (64'(total) + HALF_LSB) >> FRAC_BITS;
        if (total <= 64'sd0) begin
            return '0;
        end else if (v > 64'(LVL_ONE)) begin
            return LVL_ONE;
        end else begin
            return v[LVL_W-1:0];
        end
    endfunction

    seq_state_t         state_reg, state_next;
    init_phase_t        phase_reg, phase_next;
    stage_t             stage_reg, stage_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0] len_reg, len_next;
    logic [LVL_W-1:0]   cur_reg, cur_next;
    logic [LVL_W-1:0]   start_reg, start_next;
    logic signed [B_W-1:0] bias_reg, bias_next;
    logic [TIME_BITS-1:0] att_reg, att_next;
    logic [TIME_BITS-1:0] dec_reg, dec_next;
    logic [TIME_BITS-1:0] rel_reg, rel_next;
    logic [LVL_W-1:0]   sus_reg, sus_next;
    logic [SER_W-1:0]   e_reg, e_next;
    logic [SER_W-1:0]   e3_reg, e3_next;
    logic [LVL_W-1:0]   tab_last_reg, tab_last_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [SN_W-1:0]    ser_n_reg, ser_n_next;
    logic [SD_W-1:0]    ser_div_reg, ser_div_next;
    logic               m_valid_reg, m_valid_next;

    // payload registers
    logic [SER_W-1:0]   term_reg, term_next;
    logic [SER_W-1:0]   sum_reg, sum_next;
    logic [1:0]         ev_reg, ev_next;
    logic signed [63:0] acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic [LVL_W-1:0]   m_level_reg, m_level_next;
    logic               m_done_reg, m_done_next;

    // shared unit hookup
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_prod;
    logic                      div_start;
    logic [DIV_N_W-1:0]        div_n;
    logic [DIV_D_W-1:0]        div_d;
    logic [DIV_N_W-1:0]        div_quo;
    logic                      div_done;
    logic                      ram_we;
    logic [LVL_W-1:0]          ram_wdata;
    logic                      ram_re;
    logic [IDX_W-1:0]          ram_raddr;
    logic [LVL_W-1:0]          ram_rdata;

    // helpers
    logic [SD_W-1:0]    den_step;
    logic [NUM_W-1:0]   ser_num;
    logic [LVL_W:0]     sus_wr;
    logic [63:0]        len_w;
    logic [63:0]        att_num;
    logic [63:0]        den_e;
    logic [63:0]        den_e3;
    logic signed [63:0] dec_num;
    logic [63:0]        dec_mag;
    logic signed [B_W:0] rel_sum;
    logic               active;

    adsr_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    adsr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quotient (div_quo),
        .done     (div_done)
    );

    adsr_exp_ram #(
        .DEPTH (EXP_TABLE_DEPTH + 1),
        .WIDTH (LVL_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (k_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // operand helpers
    assign den_step = (phase_reg == INIT_TAB) ? SD_W'(EXP_TABLE_DEPTH) : SD_W'(1);
    assign ser_num  = (phase_reg == INIT_E)  ? NUM_W'(1) :
                      (phase_reg == INIT_E3) ? NUM_W'(3) : num_reg;
    assign sus_wr   = {1'b0, cfg_data[LVL_W-1:0]};
    assign len_w    = 64'(len_reg);
    assign den_e    = 64'(e_reg) - ONE_Q32;
    assign den_e3   = 64'(e3_reg) - ONE_Q32;
    assign att_num  = 64'(e_reg) - (64'(cur_reg) << (Q32 - FRAC_BITS));
    assign dec_num  = mul_prod - signed'(ONE_WIDE);
    assign dec_mag  = (dec_num < 64'sd0) ? 64'(-dec_num) : 64'(dec_num);
    assign rel_sum  = signed'({2'b00, start_reg}) + (B_W+1)'(bias_reg);
    assign active   = (stage_reg != ST_HALT) && (stage_reg != ST_RELEASE);

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == SQ_IDLE);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        stage_next    = stage_reg;
        elapsed_next  = elapsed_reg;
        len_next      = len_reg;
        cur_next      = cur_reg;
        start_next    = start_reg;
        bias_next     = bias_reg;
        att_next      = att_reg;
        dec_next      = dec_reg;
        rel_next      = rel_reg;
        sus_next      = sus_reg;
        e_next        = e_reg;
        e3_next       = e3_reg;
        tab_last_next = tab_last_reg;
        k_next        = k_reg;
        num_next      = num_reg;
        ser_n_next    = ser_n_reg;
        ser_div_next  = ser_div_reg;
        term_next     = term_reg;
        sum_next      = sum_reg;
        ev_next       = ev_reg;
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        m_level_next  = m_level_reg;
        m_done_next   = m_done_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        mul_en        = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        div_start     = 1'b0;
        div_n         = '0;
        div_d         = '0;
        ram_we        = 1'b0;
        ram_wdata     = div_quo[LVL_W-1:0];
        ram_re        = 1'b0;
        ram_raddr     = '0;

        // configuration writes
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ATTACK:  att_next = cfg_data[TIME_BITS-1:0];
                REG_DECAY:   dec_next = cfg_data[TIME_BITS-1:0];
                REG_SUSTAIN: sus_next = (sus_wr > {1'b0, LVL_ONE}) ? LVL_ONE : sus_wr[LVL_W-1:0];
                REG_RELEASE: rel_next = cfg_data[TIME_BITS-1:0];
            endcase
        end

        unique case (state_reg)
            // series sum for e, e^3 and each table entry
            SQ_SER_START: begin
                term_next    = SER_W'(ONE_Q32);
                sum_next     = SER_W'(ONE_Q32);
                ser_n_next   = SN_W'(1);
                ser_div_next = den_step;
                state_next   = SQ_SER_MUL;
            end
            SQ_SER_MUL: begin
                if (ser_n_reg > SN_W'(SERIES_TERMS) || term_reg == '0) begin
                    state_next = SQ_SER_END;
                end else begin
                    mul_en     = 1'b1;
                    mul_a      = MUL_A_W'(term_reg);
                    mul_b      = MUL_B_W'(ser_num);
                    state_next = SQ_SER_DIV;
                end
            end
            SQ_SER_DIV: begin
                div_start  = 1'b1;
                div_n      = 64'(mul_prod);
                div_d      = DIV_D_W'(ser_div_reg);
                state_next = SQ_SER_WAIT;
            end
            SQ_SER_WAIT: begin
                if (div_done) begin
                    term_next    = div_quo[SER_W-1:0];
                    sum_next     = sum_reg + div_quo[SER_W-1:0];
                    ser_n_next   = ser_n_reg + SN_W'(1);
                    ser_div_next = ser_div_reg + den_step;
                    state_next   = SQ_SER_MUL;
                end
            end
            SQ_SER_END: begin
                unique case (phase_reg)
                    INIT_E: begin
                        e_next     = sum_reg;
                        phase_next = INIT_E3;
                        state_next = SQ_SER_START;
                    end
                    INIT_E3: begin
                        e3_next    = sum_reg;
                        phase_next = INIT_TAB;
                        k_next     = '0;
                        num_next   = '0;
                        state_next = SQ_SER_START;
                    end
                    default: begin
                        div_start  = 1'b1;
                        div_n      = ONE_WIDE + 64'(sum_reg >> 1);
                        div_d      = DIV_D_W'(sum_reg);
                        state_next = SQ_TAB_WAIT;
                    end
                endcase
            end
            SQ_TAB_WAIT: begin
                if (div_done) begin
                    ram_we = 1'b1;
                    if (k_reg == IDX_LAST) begin
                        tab_last_next = div_quo[LVL_W-1:0];
                        state_next    = SQ_IDLE;
                    end else begin
                        k_next     = k_reg + IDX_W'(1);
                        num_next   = num_reg + NUM_W'(3);
                        state_next = SQ_SER_START;
                    end
                end
            end

            // sample processing
            SQ_IDLE: begin
                if (s_valid) begin
                    ev_next    = s_gate_event;
                    state_next = SQ_EVENT;
                end
            end
            SQ_EVENT: begin
                if (ev_reg == GATE_ON && !active) begin
                    stage_next   = ST_ATTACK;
                    elapsed_next = TIME_BITS'(1);
                    len_next     = len_or_one(att_reg);
                    start_next   = cur_reg;
                    div_start    = 1'b1;
                    div_n        = (att_num << FRAC_BITS) + (den_e >> 1);
                    div_d        = DIV_D_W'(den_e);
                    state_next   = SQ_BIAS_WAIT;
                end else if (ev_reg == GATE_OFF && active) begin
                    stage_next   = ST_RELEASE;
                    elapsed_next = TIME_BITS'(1);
                    len_next     = len_or_one(rel_reg);
                    start_next   = cur_reg;
                    div_start    = 1'b1;
                    div_n        = (64'(cur_reg) << Q32) + (den_e3 >> 1);
                    div_d        = DIV_D_W'(den_e3);
                    state_next   = SQ_BIAS_WAIT;
                end else begin
                    state_next = SQ_CURVE;
                end
            end
            SQ_BIAS_WAIT: begin
                if (div_done) begin
                    bias_next  = signed'(div_quo[B_W-1:0]);
                    state_next = SQ_CURVE;
                end
            end
            SQ_CURVE: begin
                if (stage_reg == ST_ATTACK || stage_reg == ST_DECAY ||
                    stage_reg == ST_RELEASE) begin
                    mul_en     = 1'b1;
                    mul_a      = MUL_A_W'(elapsed_reg);
                    mul_b      = MUL_B_W'(2 * EXP_TABLE_DEPTH);
                    state_next = SQ_IDX_DIV;
                end else begin
                    state_next = SQ_FINISH;
                end
            end
            SQ_IDX_DIV: begin
                // attack looks up exp(-t/D), the others exp(-3t/D)
                div_start = 1'b1;
                if (stage_reg == ST_ATTACK) begin
                    div_n = 64'(mul_prod) + (len_w << 1) + len_w;
                    div_d = DIV_D_W'(((len_w << 1) + len_w) << 1);
                end else begin
                    div_n = 64'(mul_prod) + len_w;
                    div_d = DIV_D_W'(len_w << 1);
                end
                state_next = SQ_IDX_WAIT;
            end
            SQ_IDX_WAIT: begin
                if (div_done) begin
                    ram_re     = 1'b1;
                    ram_raddr  = (div_quo > 64'(EXP_TABLE_DEPTH)) ? IDX_LAST
                                                                  : div_quo[IDX_W-1:0];
                    state_next = SQ_LVL1;
                end
            end
            SQ_LVL1: begin
                mul_en = 1'b1;
                case (stage_reg)
                    ST_ATTACK: begin
                        mul_a = MUL_A_W'(start_reg);
                        mul_b = MUL_B_W'(ram_rdata);
                    end
                    ST_DECAY: begin
                        mul_a = MUL_A_W'(bias_reg);
                        mul_b = MUL_B_W'(LVL_ONE - ram_rdata);
                    end
                    default: begin
                        mul_a = MUL_A_W'(rel_sum);
                        mul_b = MUL_B_W'(ram_rdata - tab_last_reg);
                    end
                endcase
                state_next = SQ_LVL2;
            end
            SQ_LVL2: begin
                case (stage_reg)
                    ST_ATTACK: begin
                        acc_next   = mul_prod;
                        mul_en     = 1'b1;
                        mul_a      = MUL_A_W'(bias_reg);
                        mul_b      = MUL_B_W'(LVL_ONE - ram_rdata);
                        state_next = SQ_LVL3;
                    end
                    ST_DECAY: begin
                        cur_next   = clamp_level(mul_prod +
                                                 signed'(64'(ram_rdata) << FRAC_BITS));
                        state_next = SQ_STAGE_END;
                    end
                    default: begin
                        cur_next   = clamp_level(mul_prod);
                        state_next = SQ_STAGE_END;
                    end
                endcase
            end
            SQ_LVL3: begin
                cur_next   = clamp_level(acc_reg + mul_prod);
                state_next = SQ_STAGE_END;
            end
            SQ_STAGE_END: begin
                state_next = SQ_FINISH;
                if (elapsed_reg >= len_reg) begin
                    case (stage_reg)
                        ST_ATTACK: begin
                            stage_next   = ST_DECAY;
                            start_next   = sus_reg;
                            len_next     = len_or_one(dec_reg);
                            elapsed_next = '0;
                            mul_en       = 1'b1;
                            mul_a        = MUL_A_W'(e3_reg);
                            mul_b        = MUL_B_W'(sus_reg);
                            state_next   = SQ_DEC_DIV;
                        end
                        ST_DECAY: stage_next = ST_SUSTAIN;
                        default: begin
                            stage_next = ST_HALT;
                            cur_next   = '0;
                        end
                    endcase
                end
            end
            SQ_DEC_DIV: begin
                // signed bias by magnitude, rounded away from zero at half
                neg_next   = dec_num < 64'sd0;
                div_start  = 1'b1;
                div_n      = dec_mag + (den_e3 >> 1);
                div_d      = DIV_D_W'(den_e3);
                state_next = SQ_DEC_WAIT;
            end
            SQ_DEC_WAIT: begin
                if (div_done) begin
                    bias_next  = neg_reg ? -signed'(div_quo[B_W-1:0])
                                         : signed'(div_quo[B_W-1:0]);
                    state_next = SQ_FINISH;
                end
            end
            SQ_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    if (elapsed_reg != TIME_MAX) begin
                        elapsed_next = elapsed_reg + TIME_BITS'(1);
                    end
                    m_valid_next = 1'b1;
                    m_level_next = (stage_reg != ST_HALT) ? cur_reg : '0;
                    m_done_next  = (stage_reg == ST_HALT);
                    state_next   = SQ_IDLE;
                end
            end
            default: state_next = SQ_IDLE;
        endcase
    end

    // control and envelope state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= SQ_SER_START;
            phase_reg    <= INIT_E;
            stage_reg    <= ST_HALT;
            elapsed_reg  <= '0;
            len_reg      <= '0;
            cur_reg      <= '0;
            start_reg    <= '0;
            bias_reg     <= '0;
            att_reg      <= TIME_BITS'(4800);
            dec_reg      <= TIME_BITS'(4800);
            sus_reg      <= LVL_ONE >> 1;
            rel_reg      <= TIME_BITS'(4800);
            k_reg        <= '0;
            num_reg      <= '0;
            ser_n_reg    <= '0;
            ser_div_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            stage_reg    <= stage_next;
            elapsed_reg  <= elapsed_next;
            len_reg      <= len_next;
            cur_reg      <= cur_next;
            start_reg    <= start_next;
            bias_reg     <= bias_next;
            att_reg      <= att_next;
            dec_reg      <= dec_next;
            sus_reg      <= sus_next;
            rel_reg      <= rel_next;
            k_reg        <= k_next;
            num_reg      <= num_next;
            ser_n_reg    <= ser_n_next;
            ser_div_reg  <= ser_div_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // working values and output word
    always_ff @(posedge aclk) begin
        e_reg        <= e_next;
        e3_reg       <= e3_next;
        tab_last_reg <= tab_last_next;
        term_reg     <= term_next;
        sum_reg      <= sum_next;
        ev_reg       <= ev_next;
        acc_reg      <= acc_next;
        neg_reg      <= neg_next;
        m_level_reg  <= m_level_next;
        m_done_reg   <= m_done_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_level    = m_level_reg;
    assign m_done_res = m_done_reg;

endmodule

@@ tb/adsr_envelope_generator_unit_tb.sv @@
// self-checking testbench for the exponential adsr envelope generator
`timescale 1ns / 1ps

module adsr_envelope_generator_unit_tb;
    import adsr_pkg::*;

    localparam int          TAB_N      = 1024;
    localparam longint      UNITY      = 64'd65536;
    localparam longint      Q32_UNITY  = 64'd1 << 32;
    localparam logic [23:0] TIME_MAX   = 24'hFFFFFF;
    localparam logic [1:0]  GATE_IDLE  = 2'd0;
    localparam logic [1:0]  GATE_BAD   = 2'd3;
    localparam int          STALL_LIMIT = 6000000;
    localparam int          PHASES     = 11;

    typedef struct packed {
        logic [16:0] level;
        logic        done;
    } level_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_ATTACK;
    logic [23:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_gate_event = GATE_IDLE;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [16:0] m_level;
    logic        m_done_res;

    adsr_envelope_generator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_gate_event(s_gate_event),
        .m_valid(m_valid), .m_ready(m_ready), .m_level(m_level), .m_done_res(m_done_res)
    );

    always #5 aclk = ~aclk;

    // envelope predictor state
    longint unsigned decay_curve [0:TAB_N];
    longint unsigned e_q, e3_q;
    longint unsigned attack_len, decay_len, sustain_tgt, release_len;
    stage_t          env_stage;
    longint unsigned env_elapsed, env_level, env_start, env_len;
    longint          env_bias;

    level_word_t     level_q [$];
    logic [1:0]      gate_q [$];
    int              errors = 0;
    int              words_in = 0;
    int              words_out = 0;
    int              watchdog = 0;
    logic            s_took = 1'b0;
    logic            calm = 1'b0;
    int              s_gap = 0;
    int              m_gap = 0;

    // e^(num/den) in q32 by a truncated series
    function automatic longint unsigned exp_q32(longint unsigned num, longint unsigned den);
        longint unsigned sum, term;
        sum = Q32_UNITY;
        term = Q32_UNITY;
        for (longint unsigned n = 1; n <= 80 && term != 0; n++) begin
            term = term * num / (den * n);
            sum += term;
        end
        return sum;
    endfunction

    function automatic longint unsigned curve_at(longint unsigned t, longint unsigned d,
                                                 bit third);
        longint unsigned idx;
        idx = third ? (2 * t * TAB_N + 3 * d) / (6 * d) : (2 * t * TAB_N + d) / (2 * d);
        if (idx > TAB_N) idx = TAB_N;
        return decay_curve[idx];
    endfunction

    function automatic longint unsigned round_clamp(longint total);
        longint unsigned v;
        if (total <= 0) return 0;
        v = (longint'(total) + (UNITY >> 1)) >> 16;
        return v > UNITY ? UNITY : v;
    endfunction

    function automatic longint unsigned at_least_one(longint unsigned v);
        return v == 0 ? 1 : v;
    endfunction

    function automatic void enter_decay();
        longint num, den;
        env_stage = ST_DECAY;
        env_start = sustain_tgt;
        env_len = at_least_one(decay_len);
        num = longint'(e3_q * env_start) - longint'(64'd1 << 48);
        den = longint'(e3_q - Q32_UNITY);
        if (num < 0) env_bias = -((-num + den / 2) / den);
        else env_bias = (num + den / 2) / den;
        env_elapsed = 0;
    endfunction

    // one sample of the envelope
    function automatic level_word_t envelope_sample(logic [1:0] gate);
        longint unsigned e, num, den;
        level_word_t w;
        if (gate == GATE_ON && (env_stage == ST_HALT || env_stage == ST_RELEASE)) begin
            env_stage = ST_ATTACK;
            env_elapsed = 1;
            env_len = at_least_one(attack_len);
            env_start = env_level;
            num = e_q - (env_start << 16);
            den = e_q - Q32_UNITY;
            env_bias = longint'((num * UNITY + den / 2) / den);
        end else if (gate == GATE_OFF && env_stage != ST_HALT && env_stage != ST_RELEASE) begin
            den = e3_q - Q32_UNITY;
            env_stage = ST_RELEASE;
            env_elapsed = 1;
            env_len = at_least_one(release_len);
            env_start = env_level;
            env_bias = longint'(((env_start << 32) + den / 2) / den);
        end
        case (env_stage)
            ST_ATTACK: begin
                e = curve_at(env_elapsed, env_len, 1'b1);
                env_level = round_clamp(longint'(env_start * e) + env_bias * longint'(UNITY - e));
                if (env_elapsed >= env_len) enter_decay();
            end
            ST_DECAY: begin
                e = curve_at(env_elapsed, env_len, 1'b0);
                env_level = round_clamp(env_bias * longint'(UNITY - e) + longint'(UNITY * e));
                if (env_elapsed >= env_len) env_stage = ST_SUSTAIN;
            end
            ST_RELEASE: begin
                e = curve_at(env_elapsed, env_len, 1'b0);
                env_level = round_clamp(longint'((env_start + longint'(env_bias)) *
                                                 (e - decay_curve[TAB_N])));
                if (env_elapsed >= env_len) begin
                    env_stage = ST_HALT;
                    env_level = 0;
                end
            end
            default: ;
        endcase
        if (env_elapsed < TIME_MAX) env_elapsed++;
        w.level = (env_stage != ST_HALT) ? env_level[16:0] : '0;
        w.done  = (env_stage == ST_HALT);
        return w;
    endfunction

    // monitor: check level words, predict on each accepted gate word
    always @(posedge aclk) begin
        level_word_t want;
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                words_out++;
                if (level_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected level word %0d", m_level);
                end else begin
                    want = level_q.pop_front();
                    if (m_level !== want.level || m_done_res !== want.done) begin
                        errors++;
                        if (errors <= 10)
                            $display("word %0d: level exp %0d got %0d, done exp %0b got %0b",
                                     words_out, want.level, m_level, want.done, m_done_res);
                    end
                end
            end
            if (s_valid && s_ready) begin
                level_q.push_back(envelope_sample(s_gate_event));
                words_in++;
            end
            s_took <= s_valid && s_ready;
            // watchdog over cycles with no handshake at all
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                watchdog <= 0;
            else if (watchdog >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end else
                watchdog <= watchdog + 1;
        end
    end

    // gate word driver with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_took) begin
            // hold until taken
        end else if (s_gap > 0) begin
            s_valid <= 1'b0;
            s_gap <= s_gap - 1;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
            s_valid <= 1'b0;
            s_gap <= $urandom_range(0, 10);
        end else if (gate_q.size() != 0) begin
            s_gate_event <= gate_q.pop_front();
            s_valid <= 1'b1;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // level channel back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_gap > 0) begin
            m_ready <= 1'b0;
            m_gap <= m_gap - 1;
        end else if (!calm && $urandom_range(0, 12) == 0) begin
            m_ready <= 1'b0;
            m_gap <= $urandom_range(0, 10);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [23:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_ATTACK:  attack_len = value;
            REG_DECAY:   decay_len = value;
            REG_SUSTAIN: sustain_tgt = (value[16:0] > UNITY) ? UNITY : value[16:0];
            default:     release_len = value;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_envelope(logic [23:0] a, logic [23:0] d, logic [23:0] s,
                                logic [23:0] r);
        write_reg(REG_ATTACK, a);
        write_reg(REG_DECAY, d);
        write_reg(REG_SUSTAIN, s);
        write_reg(REG_RELEASE, r);
    endtask

    // sender stops until every level word is back
    task automatic drain();
        @(posedge aclk);
        while (gate_q.size() != 0 || s_valid || level_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic push_n(logic [1:0] g, int n);
        repeat (n) gate_q.push_back(g);
    endtask

    // mostly whole notes with random lengths, some noise and cut-short notes
    task automatic random_notes(int count);
        int target, span;
        target = gate_q.size() + count;
        span = int'((attack_len + decay_len > 60) ? 60 : attack_len + decay_len);
        while (gate_q.size() < target) begin
            if ($urandom_range(0, 9) < 8) begin
                gate_q.push_back(GATE_ON);
                push_n(GATE_IDLE, $urandom_range(0, span + 4));
                if ($urandom_range(0, 4) == 0) gate_q.push_back(GATE_ON);
                gate_q.push_back(GATE_OFF);
                push_n(GATE_IDLE,
                       $urandom_range(0, int'(release_len > 40 ? 40 : release_len) + 4));
            end else begin
                repeat ($urandom_range(1, 6)) gate_q.push_back(2'($urandom_range(0, 3)));
            end
        end
    endtask

    function automatic logic [23:0] rand_time();
        case ($urandom_range(0, 9))
            0:       return 24'd0;
            1:       return 24'($urandom_range(0, 24'hFFFFFF));
            default: return 24'($urandom_range(1, 30));
        endcase
    endfunction

    function automatic logic [23:0] rand_sustain();
        case ($urandom_range(0, 5))
            0:       return 24'd0;
            1:       return 24'd65536;
            2:       return 24'($urandom_range(65537, 24'hFFFFFF));
            default: return 24'($urandom_range(0, 65536));
        endcase
    endfunction

    initial begin
        for (int k = 0; k <= TAB_N; k++)
            decay_curve[k] = ((64'd1 << 48) + exp_q32(3 * k, TAB_N) / 2) / exp_q32(3 * k, TAB_N);
        e_q  = exp_q32(1, 1);
        e3_q = exp_q32(3, 1);
        attack_len = 4800;
        decay_len = 4800;
        sustain_tgt = 32768;
        release_len = 4800;
        env_stage = ST_HALT;
        env_elapsed = 0;
        env_level = 0;
        env_start = 0;
        env_bias = 0;
        env_len = 0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: zero durations, ignored codes, retrigger and release restart
        set_envelope(24'd0, 24'd0, 24'hFFFFFF, 24'd0);
        gate_q = '{GATE_OFF, GATE_BAD, GATE_ON, GATE_IDLE, GATE_ON, GATE_IDLE, GATE_OFF,
                   GATE_OFF, GATE_IDLE};
        drain();
        set_envelope(24'd3, 24'd4, 24'd65536, 24'd6);
        gate_q = '{GATE_ON, GATE_IDLE, GATE_IDLE, GATE_IDLE, GATE_IDLE, GATE_BAD, GATE_IDLE,
                   GATE_OFF, GATE_IDLE, GATE_ON, GATE_IDLE, GATE_OFF, GATE_IDLE, GATE_IDLE,
                   GATE_IDLE, GATE_IDLE, GATE_IDLE, GATE_IDLE};
        drain();
        set_envelope(TIME_MAX, TIME_MAX, 24'd0, TIME_MAX);
        gate_q = '{GATE_ON, GATE_IDLE, GATE_OFF, GATE_IDLE};
        drain();

        // random phases, the last without idling
        for (int p = 0; p < PHASES; p++) begin
            set_envelope(rand_time(), rand_time(), rand_sustain(), rand_time());
            if (p == PHASES - 1) calm = 1'b1;
            random_notes(145);
            drain();
        end
        repeat (200) @(posedge aclk);

        $display("%0d gate words and %0d level words over %0d envelope settings",
                 words_in, words_out, PHASES + 3);
        if (errors == 0 && level_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d level words missing", errors, level_q.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule
